// ===== design/sga_pkg.sv =====
`default_nettype none
package sga_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W = 32;
  localparam int MU_W  = 31;
  localparam int MAG_W = 33;
  localparam int SQ_W  = 66;
  localparam int RT_W  = 33;
  localparam int MM_W  = 64;
  localparam int DEN_W = 99;
  localparam int NUM_W = 131;
  localparam int Q_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_GRAV     = 3'd3,
    REG_SOFT     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_MU_ZERO = 2'd1,
    ST_NEAR    = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef struct packed {
    logic [RT_W-1:0]         r;
    logic [SQ_W-1:0]         rem;
    logic [SQ_W-1:0]         e;
    logic [2:0][MM_W-1:0]    mm;
    logic [2:0]              neg;
    logic                    muz;
    logic                    near;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0]        den;
    logic [2:0][NUM_W-1:0]   rem;
    logic [2:0][Q_W-1:0]     q;
    logic [2:0]              ovf;
    logic [2:0]              neg;
    logic                    muz;
    logic                    near;
  } div_t;

endpackage
`default_nettype wire

// ===== design/sga_sqrt_cell.sv =====
`default_nettype none
module sga_sqrt_cell
  import sga_pkg::*;
#(
  parameter int BIT = RT_W - 1
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire sqrt_t data_i,
  output logic       valid_o,
  output sqrt_t      data_o
);

  localparam int EXT_W = SQ_W + 2;

  logic [EXT_W-1:0] trial;
  logic [EXT_W-1:0] rem_x;
  logic [EXT_W-1:0] diff;
  logic             ge;
  sqrt_t            data_d;
  logic             valid_q;
  sqrt_t            data_q;

  always_comb begin
    trial  = ({{(EXT_W-RT_W){1'b0}}, data_i.r} << (BIT + 1)) |
             ({{(EXT_W-1){1'b0}}, 1'b1} << (2 * BIT));
    rem_x  = {2'b00, data_i.rem};
    diff   = rem_x - trial;
    ge     = (rem_x >= trial);
    data_d = data_i;
    if (ge) begin
      data_d.rem    = diff[SQ_W-1:0];
      data_d.r[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== design/sga_div_cell.sv =====
`default_nettype none
module sga_div_cell
  import sga_pkg::*;
#(
  parameter int SH = Q_W
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire div_t data_i,
  output logic      valid_o,
  output div_t      data_o
);

  logic [NUM_W-1:0] dsh;
  logic [2:0]       ge;
  div_t             data_d;
  logic             valid_q;
  div_t             data_q;

  always_comb begin
    dsh    = {{(NUM_W-DEN_W){1'b0}}, data_i.den} << SH;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      ge[i] = (data_i.rem[i] >= dsh);
    end
  end

  div_t data_s;
  if (SH == Q_W) begin : g_top
    always_comb begin
      data_s     = data_d;
      data_s.ovf = ge;
    end
  end else begin : g_step
    always_comb begin
      data_s = data_d;
      for (int i = 0; i < 3; i++) begin
        if (ge[i]) begin
          data_s.rem[i]    = data_i.rem[i] - dsh;
          data_s.q[i][SH]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_s;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== design/softened_gravity_acceleration.sv =====
// Softened point-mass gravity acceleration, fixed point.
// Input channel: in_valid_i / in_stall_o with pos_x_i, pos_y_i, pos_z_i. An item
// is taken at a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with acc_x_o, acc_y_o, acc_z_o and
// status_o (0 normal, 1 mu zero, 2 too close, 3 saturated).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write only while the block is idle.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// is a row of 33 square-root cells and a row of 33 divider cells, each cell
// resolving one result bit, plus six arithmetic stages.
// When the output register holds an item and the receiver stalls, the whole
// pipeline holds and in_stall_o is raised in the same cycle.
// Reset clears every stage's valid bit and loads the registers with centers
// at zero, mu of 1.0 and a softening radius of zero (clamped to 0.001).
`default_nettype none
module softened_gravity_acceleration
  import sga_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [31:0]   pos_x_i,
  input  wire logic signed [31:0]   pos_y_i,
  input  wire logic signed [31:0]   pos_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [31:0]        acc_x_o,
  output logic signed [31:0]        acc_y_o,
  output logic signed [31:0]        acc_z_o,
  output logic [1:0]                status_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  localparam logic [63:0] ThrVal =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] SminRaw = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [63:0] SminVal = (SminRaw == 64'd0) ? 64'd1 : SminRaw;
  localparam logic [MU_W-1:0] Smin = SminVal[MU_W-1:0];
  localparam logic [SQ_W-1:0] Thr = {2'b00, ThrVal};
  localparam int SqSteps  = RT_W;
  localparam int DivSteps = Q_W + 1;
  localparam int HalfE    = SQ_W / 2;

  // configuration
  logic [2:0][POS_W-1:0] center_q;
  logic [MU_W-1:0]       mu_q;
  logic [MU_W-1:0]       soft_q;
  logic [MU_W-1:0]       soft_c;
  logic [2*MU_W-1:0]     soft2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      mu_q     <= MU_W'(65536);
      soft_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: center_q[0] <= cfg_data_i;
        REG_CENTER_Y: center_q[1] <= cfg_data_i;
        REG_CENTER_Z: center_q[2] <= cfg_data_i;
        REG_GRAV:     mu_q        <= cfg_data_i[MU_W-1:0];
        REG_SOFT:     soft_q      <= cfg_data_i[MU_W-1:0];
        default: ;
      endcase
    end
  end

  assign soft_c = (soft_q > Smin) ? soft_q : Smin;

  always_ff @(posedge clk_i) begin
    soft2_q <= soft_c * soft_c;
  end

  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: delta and magnitude
  logic [2:0][POS_W-1:0] pos;
  logic [2:0][MAG_W-1:0] dlt;
  logic                  s1_v_q;
  logic [2:0][MAG_W-1:0] s1_mag_q;
  logic [2:0]            s1_neg_q;

  assign pos = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i] = {center_q[i][POS_W-1], center_q[i]} - {pos[i][POS_W-1], pos[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_q[i] <= dlt[i][MAG_W-1];
        s1_mag_q[i] <= dlt[i][MAG_W-1] ? (MAG_W'(0) - dlt[i]) : dlt[i];
      end
    end
  end

  // stage 2: squares and mu products
  logic                  s2_v_q;
  logic [2:0][SQ_W-1:0]  s2_sq_q;
  logic [2:0][MM_W-1:0]  s2_mm_q;
  logic [2:0]            s2_neg_q;
  logic                  s2_muz_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= s1_mag_q[i] * s1_mag_q[i];
        s2_mm_q[i] <= s1_mag_q[i] * mu_q;
      end
      s2_neg_q <= s1_neg_q;
      s2_muz_q <= (mu_q == '0);
    end
  end

  // stage 3: squared distance, softened denominator term
  logic [SQ_W-1:0] d2;
  logic [SQ_W-1:0] soft2_x;
  logic            s3_v_q;
  sqrt_t           s3_q;

  assign d2      = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
  assign soft2_x = {{(SQ_W-2*MU_W){1'b0}}, soft2_q};

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      s3_q.r    <= '0;
      s3_q.rem  <= d2;
      s3_q.e    <= (soft2_x <= d2) ? d2 : soft2_x;
      s3_q.mm   <= s2_mm_q;
      s3_q.neg  <= s2_neg_q;
      s3_q.muz  <= s2_muz_q;
      s3_q.near <= (d2 <= Thr);
    end
  end

  // square-root row
  logic  sq_v [SqSteps+1];
  sqrt_t sq_d [SqSteps+1];

  assign sq_v[0] = s3_v_q;
  assign sq_d[0] = s3_q;

  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    sga_sqrt_cell #(.BIT(RT_W - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[j]),
      .data_i  (sq_d[j]),
      .valid_o (sq_v[j+1]),
      .data_o  (sq_d[j+1])
    );
  end

  // stage A: partial products of the denominator
  logic                     pa_v_q;
  logic [SQ_W-1:0]          pa_lo_q;
  logic [SQ_W-1:0]          pa_hi_q;
  logic [2:0][MM_W-1:0]     pa_mm_q;
  logic [2:0]               pa_neg_q;
  logic                     pa_muz_q;
  logic                     pa_near_q;

  always_ff @(posedge clk_i) begin
    if (adv && sq_v[SqSteps]) begin
      pa_lo_q   <= sq_d[SqSteps].e[HalfE-1:0] * sq_d[SqSteps].r;
      pa_hi_q   <= sq_d[SqSteps].e[SQ_W-1:HalfE] * sq_d[SqSteps].r;
      pa_mm_q   <= sq_d[SqSteps].mm;
      pa_neg_q  <= sq_d[SqSteps].neg;
      pa_muz_q  <= sq_d[SqSteps].muz;
      pa_near_q <= sq_d[SqSteps].near;
    end
  end

  // stage B: denominator and scaled numerators
  logic  pb_v_q;
  div_t  pb_q;

  always_ff @(posedge clk_i) begin
    if (adv && pa_v_q) begin
      pb_q.den <= {{(DEN_W-SQ_W){1'b0}}, pa_lo_q} +
                  ({{(DEN_W-SQ_W){1'b0}}, pa_hi_q} << HalfE);
      for (int i = 0; i < 3; i++) begin
        pb_q.rem[i] <= {{(NUM_W-MM_W){1'b0}}, pa_mm_q[i]} << (2 * FRAC_BITS);
      end
      pb_q.q    <= '0;
      pb_q.ovf  <= '0;
      pb_q.neg  <= pa_neg_q;
      pb_q.muz  <= pa_muz_q;
      pb_q.near <= pa_near_q;
    end
  end

  // divider row
  logic dv_v [DivSteps+1];
  div_t dv_d [DivSteps+1];

  assign dv_v[0] = pb_v_q;
  assign dv_d[0] = pb_q;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    sga_div_cell #(.SH(Q_W - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[j]),
      .data_i  (dv_d[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv_d[j+1])
    );
  end

  // output stage
  div_t                 fin;
  logic [2:0][Q_W-1:0]  lim;
  logic [2:0][Q_W-1:0]  mag_o;
  logic [2:0][Q_W-1:0]  acc_c;
  logic [2:0]           sat;
  status_e              status_c;
  logic [2:0][Q_W-1:0]  acc_q;
  status_e              status_q;

  assign fin = dv_d[DivSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]   = fin.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat[i]   = fin.ovf[i] || (fin.q[i] > lim[i]);
      mag_o[i] = sat[i] ? lim[i] : fin.q[i];
      acc_c[i] = fin.neg[i] ? (Q_W'(0) - mag_o[i]) : mag_o[i];
    end
    if (fin.muz) begin
      status_c = ST_MU_ZERO;
      acc_c    = '0;
    end else if (fin.near) begin
      status_c = ST_NEAR;
      acc_c    = '0;
    end else if (|sat) begin
      status_c = ST_SAT;
    end else begin
      status_c = ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && dv_v[DivSteps]) begin
      acc_q    <= acc_c;
      status_q <= status_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      pa_v_q      <= 1'b0;
      pb_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      pa_v_q      <= sq_v[SqSteps];
      pb_v_q      <= pa_v_q;
      out_valid_q <= dv_v[DivSteps];
    end
  end

  assign out_valid_o = out_valid_q;
  assign acc_x_o     = acc_q[0];
  assign acc_y_o     = acc_q[1];
  assign acc_z_o     = acc_q[2];
  assign status_o    = status_q;

endmodule
`default_nettype wire

// ===== design/sga_checker.sv =====
`default_nettype none
module sga_checker
  import sga_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic signed [31:0]   acc_x_o,
  input wire logic signed [31:0]   acc_y_o,
  input wire logic signed [31:0]   acc_z_o,
  input wire logic [1:0]           status_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o
);

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_zero_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MU_ZERO || status_o == ST_NEAR) |->
      acc_x_o == 0 && acc_y_o == 0 && acc_z_o == 0)
    else $error("nonzero acceleration on a zero status");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind softened_gravity_acceleration sga_checker u_sga_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .acc_x_o     (acc_x_o),
  .acc_y_o     (acc_y_o),
  .acc_z_o     (acc_z_o),
  .status_o    (status_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
